### rtl/core/mtbbt_pkg.sv
`default_nettype none

package mtbbt_pkg;

  localparam int unsigned BEAT_TICKS = 1920;
  localparam int unsigned TICK_FRAC_BITS = 16;
  // seconds per minute times tempo scale
  localparam int unsigned RATE_SCALE = 15360;

  localparam int unsigned TICK_W    = 27;
  localparam int unsigned DIV_DVD_W = 66;
  localparam int unsigned DIV_DSR_W = 33;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_DVD_W);

  localparam logic [TICK_W-1:0] TICK_ONE = TICK_W'(BEAT_TICKS << TICK_FRAC_BITS);
  localparam logic [TICK_W:0]   TICK_HALF = (TICK_W+1)'(1) << (TICK_FRAC_BITS - 1);

  typedef enum logic [2:0] {
    OP_PROCESS  = 3'd0,
    OP_PAUSE    = 3'd1,
    OP_RELOCATE = 3'd2,
    OP_RESYNC   = 3'd3,
    OP_START    = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_TRANSPORT_INTERNAL = 2'd0,
    CFG_BEATS_PER_BAR      = 2'd1,
    CFG_TEMPO_Q8           = 2'd2,
    CFG_SAMPLE_RATE        = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    STG_BEATS = 3'd0,
    STG_TICK  = 3'd1,
    STG_BAR   = 3'd2,
    STG_INC   = 3'd3,
    STG_CARRY = 3'd4,
    STG_FOLD  = 3'd5
  } stage_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_GO     = 3'd2,
    ST_WAIT   = 3'd3,
    ST_FINISH = 3'd4
  } state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] frames;
    logic [47:0] position;
  } in_req_t;

  typedef struct packed {
    logic [30:0] bar;
    logic [4:0]  beat;
    logic [26:0] tick_fixed;
    logic [10:0] tick_rounded;
    logic [47:0] bar_origin;
    logic [47:0] frame_now;
    logic        playing;
    logic        bbt_valid;
  } out_rsp_t;

  typedef struct packed {
    logic   capture;
    logic   apply_op;
    logic   load_frame;
    logic   div_start;
    logic   div_take;
    logic   load_out;
    stage_e stage;
  } ctrl_cmd_t;

  typedef struct packed {
    logic op_process;
    logic proc_active;
    logic resync_pending;
    logic playing;
    logic div_busy;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/musical_transport_bbt_tracker.sv
`default_nettype none

// channel    direction  signals                          payload
// in         request    in_valid_i / in_ready_o          in_req_i (opcode, frames, position)
// out        result     out_valid_o / out_ready_i        out_rsp_o (bar .. bbt_valid)
// cfg        write      cfg_we_i                          cfg_index_i, cfg_data_i
//
// one request at a time; commands and empty blocks skip the divider and go straight to the result
// a resync or a playing advance takes three passes of the 66-step radix-2 divider
// reset restores the register defaults and clears the transport position
// the result register frees the input side; a request that finishes while the previous
// result still waits holds until that result is taken

module musical_transport_bbt_tracker (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire mtbbt_pkg::in_req_t   in_req_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output mtbbt_pkg::out_rsp_t       out_rsp_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [18:0]          cfg_data_i
);

  mtbbt_pkg::ctrl_cmd_t  cmd;
  mtbbt_pkg::dp_status_t status;

  mtbbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mtbbt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  a_one_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request accepted while another is in flight");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

### rtl/core/mtbbt_divider.sv
`default_nettype none

module mtbbt_divider (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [mtbbt_pkg::DIV_DVD_W-1:0]    dividend_i,
  input  wire logic [mtbbt_pkg::DIV_DSR_W-1:0]    divisor_i,
  output logic                                    busy_o,
  output logic                                    done_o,
  output logic [mtbbt_pkg::DIV_DVD_W-1:0]         quotient_o,
  output logic [mtbbt_pkg::DIV_DSR_W-1:0]         remainder_o
);

  logic [mtbbt_pkg::DIV_DVD_W-1:0] dvd_q, dvd_d;
  logic [mtbbt_pkg::DIV_DSR_W-1:0] dsr_q, dsr_d;
  logic [mtbbt_pkg::DIV_DSR_W-1:0] rem_q, rem_d;
  logic [mtbbt_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [mtbbt_pkg::DIV_DSR_W:0]   trial;
  logic [mtbbt_pkg::DIV_DSR_W:0]   diff;
  logic                            fits;

  assign trial = {rem_q, dvd_q[mtbbt_pkg::DIV_DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      dsr_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[mtbbt_pkg::DIV_DSR_W-1:0] : trial[mtbbt_pkg::DIV_DSR_W-1:0];
      dvd_d = {dvd_q[mtbbt_pkg::DIV_DVD_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mtbbt_pkg::DIV_CNT_W'(mtbbt_pkg::DIV_DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign busy_o      = busy_q;
  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

### rtl/core/mtbbt_datapath.sv
`default_nettype none

module mtbbt_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mtbbt_pkg::ctrl_cmd_t  cmd_i,
  output mtbbt_pkg::dp_status_t      status_o,
  input  wire mtbbt_pkg::in_req_t    in_req_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [18:0]           cfg_data_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output mtbbt_pkg::out_rsp_t        out_rsp_o
);

  // configuration
  logic        internal_q, internal_d;
  logic [4:0]  bpb_q, bpb_d;
  logic [17:0] tempo_q, tempo_d;
  logic [18:0] rate_q, rate_d;

  // transport state
  logic [47:0] frame_pos_q, frame_pos_d;
  logic [47:0] next_frame_q, next_frame_d;
  logic        playing_q, playing_d;
  logic        resync_q, resync_d;
  logic [30:0] bar_count_q, bar_count_d;
  logic [4:0]  beat_count_q, beat_count_d;
  logic [26:0] tick_q, tick_d;
  logic [47:0] bar_start_q, bar_start_d;
  logic        pos_valid_q, pos_valid_d;

  // work registers
  mtbbt_pkg::in_req_t item_q, item_d;
  logic [33:0] prod_q, prod_d;
  logic [63:0] beats_q, beats_d;
  logic [32:0] rem_q, rem_d;
  logic [36:0] total_q, total_d;

  logic                 out_valid_q, out_valid_d;
  mtbbt_pkg::out_rsp_t  out_q, out_d;

  logic [4:0]                          bpb_eff;
  logic [mtbbt_pkg::DIV_DSR_W-1:0]     d_full;
  logic [mtbbt_pkg::DIV_DVD_W-1:0]     div_dvd;
  logic [mtbbt_pkg::DIV_DSR_W-1:0]     div_dsr;
  logic [mtbbt_pkg::DIV_DVD_W-1:0]     div_quot;
  logic [mtbbt_pkg::DIV_DSR_W-1:0]     div_rem;
  logic                                div_busy;
  logic                                div_done;
  logic [mtbbt_pkg::TICK_W:0]          round_sum;
  logic [mtbbt_pkg::TICK_W:0]          frac_sum;
  logic                                tick_carry;

  assign bpb_eff = (bpb_q == 5'd0) ? 5'd1 : bpb_q;
  assign d_full  = mtbbt_pkg::DIV_DSR_W'(rate_q) * mtbbt_pkg::DIV_DSR_W'(mtbbt_pkg::RATE_SCALE);

  always_comb begin
    div_dvd = '0;
    div_dsr = '0;
    case (cmd_i.stage)
      mtbbt_pkg::STG_BEATS: begin
        div_dvd = mtbbt_pkg::DIV_DVD_W'(frame_pos_q) * mtbbt_pkg::DIV_DVD_W'(tempo_q);
        div_dsr = d_full;
      end
      mtbbt_pkg::STG_TICK: begin
        div_dvd = mtbbt_pkg::DIV_DVD_W'(rem_q) * mtbbt_pkg::DIV_DVD_W'(mtbbt_pkg::TICK_ONE);
        div_dsr = d_full;
      end
      mtbbt_pkg::STG_BAR: begin
        div_dvd = mtbbt_pkg::DIV_DVD_W'(beats_q);
        div_dsr = mtbbt_pkg::DIV_DSR_W'(bpb_eff);
      end
      mtbbt_pkg::STG_INC: begin
        div_dvd = mtbbt_pkg::DIV_DVD_W'(prod_q);
        div_dsr = d_full;
      end
      mtbbt_pkg::STG_CARRY: begin
        div_dvd = mtbbt_pkg::DIV_DVD_W'(rem_q) * mtbbt_pkg::DIV_DVD_W'(mtbbt_pkg::TICK_ONE);
        div_dsr = d_full;
      end
      mtbbt_pkg::STG_FOLD: begin
        div_dvd = mtbbt_pkg::DIV_DVD_W'(total_q);
        div_dsr = mtbbt_pkg::DIV_DSR_W'(bpb_eff);
      end
      default: begin
        div_dvd = '0;
        div_dsr = '0;
      end
    endcase
  end

  mtbbt_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dsr),
    .busy_o      (div_busy),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  assign round_sum = (mtbbt_pkg::TICK_W+1)'(tick_q) + mtbbt_pkg::TICK_HALF;

  // fraction of the block increment added to the tick, at most one beat of carry
  assign frac_sum   = (mtbbt_pkg::TICK_W+1)'(tick_q)
                      + (mtbbt_pkg::TICK_W+1)'(div_quot[mtbbt_pkg::TICK_W-1:0]);
  assign tick_carry = frac_sum >= (mtbbt_pkg::TICK_W+1)'(mtbbt_pkg::TICK_ONE);

  always_comb begin
    internal_d   = internal_q;
    bpb_d        = bpb_q;
    tempo_d      = tempo_q;
    rate_d       = rate_q;
    frame_pos_d  = frame_pos_q;
    next_frame_d = next_frame_q;
    playing_d    = playing_q;
    resync_d     = resync_q;
    bar_count_d  = bar_count_q;
    beat_count_d = beat_count_q;
    tick_d       = tick_q;
    bar_start_d  = bar_start_q;
    pos_valid_d  = pos_valid_q;
    item_d       = item_q;
    prod_d       = prod_q;
    beats_d      = beats_q;
    rem_d        = rem_q;
    total_d      = total_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        mtbbt_pkg::CFG_TRANSPORT_INTERNAL: internal_d = cfg_data_i[0];
        mtbbt_pkg::CFG_BEATS_PER_BAR:      bpb_d      = cfg_data_i[4:0];
        mtbbt_pkg::CFG_TEMPO_Q8:           tempo_d    = cfg_data_i[17:0];
        mtbbt_pkg::CFG_SAMPLE_RATE:        rate_d     = cfg_data_i;
        default: ;
      endcase
    end

    if (cmd_i.capture) begin
      item_d = in_req_i;
    end

    if (cmd_i.apply_op) begin
      case (item_q.opcode)
        mtbbt_pkg::OP_PAUSE: begin
          playing_d    = 1'b0;
          next_frame_d = frame_pos_q;
          resync_d     = 1'b1;
        end
        mtbbt_pkg::OP_RELOCATE: begin
          frame_pos_d  = item_q.position;
          next_frame_d = item_q.position;
          resync_d     = 1'b1;
        end
        mtbbt_pkg::OP_RESYNC: begin
          resync_d = 1'b1;
        end
        mtbbt_pkg::OP_START: begin
          playing_d = 1'b1;
          resync_d  = 1'b1;
        end
        default: ;
      endcase
    end

    if (cmd_i.load_frame) begin
      frame_pos_d = internal_q ? next_frame_q : item_q.position;
      prod_d      = 34'(item_q.frames) * 34'(tempo_q);
      if (internal_q && playing_q) begin
        next_frame_d = next_frame_q + 48'(item_q.frames);
      end
    end

    if (cmd_i.div_take) begin
      case (cmd_i.stage)
        mtbbt_pkg::STG_BEATS: begin
          beats_d = div_quot[63:0];
          rem_d   = div_rem;
        end
        mtbbt_pkg::STG_TICK: begin
          tick_d = div_quot[26:0];
        end
        mtbbt_pkg::STG_BAR: begin
          bar_count_d  = div_quot[30:0];
          beat_count_d = div_rem[4:0];
          bar_start_d  = (beats_q[47:0] - 48'(div_rem)) * 48'(mtbbt_pkg::BEAT_TICKS);
          pos_valid_d  = 1'b1;
          resync_d     = 1'b0;
        end
        mtbbt_pkg::STG_INC: begin
          beats_d = div_quot[63:0];
          rem_d   = div_rem;
        end
        mtbbt_pkg::STG_CARRY: begin
          tick_d  = tick_carry ? frac_sum[26:0] - mtbbt_pkg::TICK_ONE : frac_sum[26:0];
          total_d = 37'(beat_count_q) + beats_q[36:0] + 37'(tick_carry);
        end
        mtbbt_pkg::STG_FOLD: begin
          beat_count_d = div_rem[4:0];
          bar_count_d  = bar_count_q + div_quot[30:0];
          bar_start_d  = bar_start_q
                         + (48'(total_q) - 48'(div_rem)) * 48'(mtbbt_pkg::BEAT_TICKS);
        end
        default: ;
      endcase
    end

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d          = 1'b1;
      out_d.bar            = bar_count_q + 31'd1;
      out_d.beat           = beat_count_q + 5'd1;
      out_d.tick_fixed     = tick_q;
      out_d.tick_rounded   = round_sum[mtbbt_pkg::TICK_FRAC_BITS +: 11];
      out_d.bar_origin     = bar_start_q;
      out_d.frame_now      = frame_pos_q;
      out_d.playing        = playing_q;
      out_d.bbt_valid      = pos_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      internal_q   <= 1'b1;
      bpb_q        <= 5'd4;
      tempo_q      <= 18'd30720;
      rate_q       <= '0;
      frame_pos_q  <= '0;
      next_frame_q <= '0;
      playing_q    <= 1'b0;
      resync_q     <= 1'b0;
      bar_count_q  <= '0;
      beat_count_q <= '0;
      tick_q       <= '0;
      bar_start_q  <= '0;
      pos_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      internal_q   <= internal_d;
      bpb_q        <= bpb_d;
      tempo_q      <= tempo_d;
      rate_q       <= rate_d;
      frame_pos_q  <= frame_pos_d;
      next_frame_q <= next_frame_d;
      playing_q    <= playing_d;
      resync_q     <= resync_d;
      bar_count_q  <= bar_count_d;
      beat_count_q <= beat_count_d;
      tick_q       <= tick_d;
      bar_start_q  <= bar_start_d;
      pos_valid_q  <= pos_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    prod_q  <= prod_d;
    beats_q <= beats_d;
    rem_q   <= rem_d;
    total_q <= total_d;
    out_q   <= out_d;
  end

  always_comb begin
    status_o.op_process     = item_q.opcode == mtbbt_pkg::OP_PROCESS;
    status_o.proc_active    = (item_q.frames != 16'd0) && (rate_q != 19'd0);
    status_o.resync_pending = resync_q;
    status_o.playing        = playing_q;
    status_o.div_busy       = div_busy;
    status_o.div_done       = div_done;
    status_o.out_free       = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

### rtl/core/mtbbt_ctrl.sv
`default_nettype none

module mtbbt_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire mtbbt_pkg::dp_status_t  status_i,
  output mtbbt_pkg::ctrl_cmd_t        cmd_o
);

  mtbbt_pkg::state_e state_q, state_d;
  mtbbt_pkg::stage_e stage_q, stage_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtbbt_pkg::ST_IDLE;
      stage_q <= mtbbt_pkg::STG_BEATS;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    stage_d          = stage_q;
    in_ready_o       = 1'b0;
    cmd_o.capture    = 1'b0;
    cmd_o.apply_op   = 1'b0;
    cmd_o.load_frame = 1'b0;
    cmd_o.div_start  = 1'b0;
    cmd_o.div_take   = 1'b0;
    cmd_o.load_out   = 1'b0;
    cmd_o.stage      = stage_q;
    case (state_q)
      mtbbt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mtbbt_pkg::ST_DECODE;
        end
      end
      mtbbt_pkg::ST_DECODE: begin
        if (!status_i.op_process) begin
          cmd_o.apply_op = 1'b1;
          state_d        = mtbbt_pkg::ST_FINISH;
        end else if (!status_i.proc_active) begin
          state_d = mtbbt_pkg::ST_FINISH;
        end else begin
          cmd_o.load_frame = 1'b1;
          if (status_i.resync_pending) begin
            stage_d = mtbbt_pkg::STG_BEATS;
            state_d = mtbbt_pkg::ST_GO;
          end else if (status_i.playing) begin
            stage_d = mtbbt_pkg::STG_INC;
            state_d = mtbbt_pkg::ST_GO;
          end else begin
            state_d = mtbbt_pkg::ST_FINISH;
          end
        end
      end
      mtbbt_pkg::ST_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = mtbbt_pkg::ST_WAIT;
      end
      mtbbt_pkg::ST_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.div_take = 1'b1;
          state_d        = mtbbt_pkg::ST_GO;
          case (stage_q)
            mtbbt_pkg::STG_BEATS: stage_d = mtbbt_pkg::STG_TICK;
            mtbbt_pkg::STG_TICK:  stage_d = mtbbt_pkg::STG_BAR;
            mtbbt_pkg::STG_INC:   stage_d = mtbbt_pkg::STG_CARRY;
            mtbbt_pkg::STG_CARRY: stage_d = mtbbt_pkg::STG_FOLD;
            default:              state_d = mtbbt_pkg::ST_FINISH;
          endcase
        end
      end
      mtbbt_pkg::ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = mtbbt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mtbbt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
